// ----- rtl/core/owre_pkg.sv -----
// Shared types, codes and CRC-8 helpers for the one-wire request/response engine.
// Used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package owre_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [7:0]  CRC_POLY       = 8'h07;
    localparam logic [7:0]  CRC_SEED_RST   = 8'hAC;
    localparam logic [6:0]  GRACE_RST      = 7'd100;
    localparam logic [7:0]  REQ_TOUCH      = 8'h40;
    localparam logic [7:0]  REQ_PANEL_INFO = 8'h60;
    localparam logic [11:0] COORD_NONE     = 12'hFFF;
    localparam logic [7:0]  NO_PANEL       = 8'hFF;
    localparam logic [14:0] FW_YEAR_SCALE  = 15'd100;
    localparam logic [5:0]  REQ_BITS       = 6'd16;
    localparam logic [5:0]  RESP_BITS      = 6'd32;
    localparam logic [5:0]  GAP_TICKS      = 6'd2;
    localparam logic [5:0]  CRC_LAST_BIT   = 6'd8;
    localparam logic [6:0]  RX_COUNT_MAX   = 7'd127;
    localparam logic [15:0] ERR_COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_REQUEST,
        PH_WAITING,
        PH_RESPONSE,
        PH_STOPPING
    } t_phase;

    typedef enum logic {
        ACT_START,
        ACT_TICK
    } t_action;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_ACCEPTED,
        ST_CRC_ERROR,
        ST_REFUSED
    } t_status;

    typedef enum logic [1:0] {
        KIND_TOUCH,
        KIND_INFO,
        KIND_BACKLIGHT
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_SEED,
        CFG_ERROR_GRACE
    } t_cfg_idx;

    typedef struct packed {
        logic       action;
        logic [7:0] request_code;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic        line_drive;
        logic        line_drive_enable;
        logic        timer_active;
        logic [1:0]  session_status;
        logic [1:0]  result_kind;
        logic [11:0] touch_x;
        logic [11:0] touch_y;
        logic        touch_pressed;
        logic [7:0]  panel_type;
        logic [14:0] firmware_version;
        logic [15:0] error_count;
        logic        backlight_ready;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [7:0]           wdata;
    } t_cfg_write;

    typedef struct packed {
        logic [7:0] crc_seed;
        logic [6:0] error_grace;
    } t_cfg;

    // One MSB-first bit into the CRC-8 register.
    function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic din);
        logic fb;
        fb = crc[7] ^ din;
        return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = crc8_bit(c, v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/owre_chan_if.sv -----
// Valid/ready channel carrying one payload struct.
// The payload type comes from owre_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface owre_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/owre_cfg_regs.sv -----
// Configuration register file: CRC seed and error grace count.
// Depends on owre_pkg for the register index codes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module owre_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_valid,
    input  owre_pkg::t_cfg_write     i_wr,
    output owre_pkg::t_cfg           o_cfg
);
    import owre_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_seed    <= CRC_SEED_RST;
            r_cfg.error_grace <= GRACE_RST;
        end else if (i_wr_valid) begin
            case (t_cfg_idx'(i_wr.reg_index))
                CFG_CRC_SEED:    r_cfg.crc_seed    <= i_wr.wdata;
                CFG_ERROR_GRACE: r_cfg.error_grace <= i_wr.wdata[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/owre_in_reg.sv -----
// Input register: holds one accepted item until the session logic takes it.
// Depends on owre_pkg for the input item type.
`timescale 1ns / 1ps
`default_nettype none

module owre_in_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  owre_pkg::t_in_item    i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output owre_pkg::t_in_item    o_item,
    input  wire logic             i_take
);
    import owre_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // A new transfer is taken when the register is empty or drains this cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- rtl/core/owre_session.sv -----
// Session sequencer: bit timing, request shifting, response sampling, CRC check
// and frame decode, with the result register. Depends on owre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owre_session (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  owre_pkg::t_cfg        i_cfg,
    input  wire logic             i_item_valid,
    input  owre_pkg::t_in_item    i_item,
    output logic                  o_take,
    output logic                  o_out_valid,
    output owre_pkg::t_out_item   o_out,
    input  wire logic             i_out_ready
);
    import owre_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [5:0]  r_bit_count,   n_bit_count;
    logic [31:0] r_shift,       n_shift;
    logic [7:0]  r_pending,     n_pending;
    logic [6:0]  r_rx_count,    n_rx_count;
    logic [15:0] r_err_total,   n_err_total;
    logic [7:0]  r_panel,       n_panel;
    logic [14:0] r_firmware,    n_firmware;
    logic        r_backlight,   n_backlight;
    logic        r_drive_level, n_drive_level;
    logic        r_drive_en,    n_drive_en;
    logic [7:0]  r_crc,         n_crc;
    logic        r_out_valid;
    t_out_item   r_out,         n_out;

    logic        fire;
    logic [5:0]  bc_dec;
    logic [31:0] sh_in;
    logic [11:0] tx;
    logic [11:0] ty;
    t_status     status;
    t_kind       kind;
    logic        pressed;

    assign o_take = !r_out_valid || i_out_ready;
    assign fire   = i_item_valid && o_take;
    assign bc_dec = r_bit_count - 6'd1;
    assign sh_in  = {r_shift[30:0], i_item.line_level};
    assign tx     = {sh_in[31:28], sh_in[23:16]};
    assign ty     = {sh_in[27:24], sh_in[15:8]};

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_pending     = r_pending;
        n_rx_count    = r_rx_count;
        n_err_total   = r_err_total;
        n_panel       = r_panel;
        n_firmware    = r_firmware;
        n_backlight   = r_backlight;
        n_drive_level = r_drive_level;
        n_drive_en    = r_drive_en;
        n_crc         = r_crc;
        status        = ST_NONE;
        kind          = KIND_TOUCH;
        pressed       = 1'b0;

        if (t_action'(i_item.action) == ACT_START) begin
            if (r_phase != PH_IDLE) begin
                status = ST_REFUSED;
            end else begin
                n_shift       = {i_item.request_code,
                                 crc8_byte(i_cfg.crc_seed, i_item.request_code), 16'h0000};
                n_pending     = i_item.request_code;
                n_bit_count   = 6'd1;
                n_phase       = PH_START;
                n_drive_en    = 1'b1;
                n_drive_level = 1'b0;
            end
        end else if (r_phase != PH_IDLE) begin
            n_bit_count = bc_dec;
            case (r_phase)
                PH_START: begin
                    if (bc_dec == 6'd0) begin
                        n_bit_count = REQ_BITS;
                        n_phase     = PH_REQUEST;
                    end
                end
                PH_REQUEST: begin
                    n_drive_level = r_shift[31];
                    n_shift       = {r_shift[30:0], 1'b0};
                    if (bc_dec == 6'd0) begin
                        n_bit_count = GAP_TICKS;
                        n_phase     = PH_WAITING;
                    end
                end
                PH_WAITING: begin
                    if (bc_dec == 6'd0) begin
                        n_bit_count = RESP_BITS;
                        n_phase     = PH_RESPONSE;
                        n_crc       = i_cfg.crc_seed;
                    end
                    if (bc_dec == 6'd1) begin
                        n_drive_level = 1'b1;
                        n_drive_en    = 1'b0;
                    end
                end
                PH_RESPONSE: begin
                    n_shift = sh_in;
                    // The CRC runs over the first three bytes as they arrive.
                    if (bc_dec >= CRC_LAST_BIT) begin
                        n_crc = crc8_bit(r_crc, i_item.line_level);
                    end
                    if (bc_dec == 6'd0) begin
                        n_bit_count   = GAP_TICKS;
                        n_phase       = PH_STOPPING;
                        n_drive_level = 1'b1;
                        n_drive_en    = 1'b1;
                        if (r_rx_count < RX_COUNT_MAX) begin
                            n_rx_count = r_rx_count + 7'd1;
                        end
                        if (r_crc != sh_in[7:0]) begin
                            status = ST_CRC_ERROR;
                            if (n_rx_count > i_cfg.error_grace &&
                                r_err_total != ERR_COUNT_MAX) begin
                                n_err_total = r_err_total + 16'd1;
                            end
                        end else begin
                            status = ST_ACCEPTED;
                            if (r_pending == REQ_TOUCH) begin
                                kind    = KIND_TOUCH;
                                pressed = (tx != COORD_NONE) && (ty != COORD_NONE);
                            end else if (r_pending == REQ_PANEL_INFO) begin
                                kind = KIND_INFO;
                                if (sh_in[31:24] != NO_PANEL) begin
                                    n_panel    = sh_in[31:24];
                                    n_firmware = 15'(sh_in[23:16]) * FW_YEAR_SCALE
                                               + 15'(sh_in[15:8]);
                                end
                            end else begin
                                kind        = KIND_BACKLIGHT;
                                n_backlight = 1'b1;
                            end
                        end
                    end
                end
                PH_STOPPING: begin
                    if (bc_dec == 6'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_out.line_drive        = n_drive_level;
        n_out.line_drive_enable = n_drive_en;
        n_out.timer_active      = (n_phase != PH_IDLE);
        n_out.session_status    = status;
        n_out.result_kind       = kind;
        n_out.touch_x           = (status == ST_ACCEPTED && kind == KIND_TOUCH) ? tx : 12'h000;
        n_out.touch_y           = (status == ST_ACCEPTED && kind == KIND_TOUCH) ? ty : 12'h000;
        n_out.touch_pressed     = pressed;
        n_out.panel_type        = n_panel;
        n_out.firmware_version  = n_firmware;
        n_out.error_count       = n_err_total;
        n_out.backlight_ready   = n_backlight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= 6'd0;
            r_shift       <= 32'h0;
            r_pending     <= 8'h00;
            r_rx_count    <= 7'd0;
            r_err_total   <= 16'h0000;
            r_panel       <= 8'h00;
            r_firmware    <= 15'd0;
            r_backlight   <= 1'b0;
            r_drive_level <= 1'b1;
            r_drive_en    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_phase       <= n_phase;
                r_bit_count   <= n_bit_count;
                r_shift       <= n_shift;
                r_pending     <= n_pending;
                r_rx_count    <= n_rx_count;
                r_err_total   <= n_err_total;
                r_panel       <= n_panel;
                r_firmware    <= n_firmware;
                r_backlight   <= n_backlight;
                r_drive_level <= n_drive_level;
                r_drive_en    <= n_drive_en;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_crc <= n_crc;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_refuse_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && t_action'(i_item.action) == ACT_START && r_phase != PH_IDLE
        |=> r_out.session_status == ST_REFUSED)
        else $error("start while busy was not refused");

    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_err_total >= $past(r_err_total))
        else $error("error counter went down");

    a_drive_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START || r_phase == PH_REQUEST) |-> r_drive_en)
        else $error("line released while sending the request");

    a_release_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RESPONSE |-> !r_drive_en && r_drive_level)
        else $error("line driven while sampling the response");

endmodule

`default_nettype wire

// ----- rtl/core/one_wire_request_response_engine.sv -----
// Top level of the one-wire request/response engine.
// Depends on owre_pkg, owre_chan_if, owre_cfg_regs, owre_in_reg and owre_session.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Dir  Payload        Meaning
//  i_in      in   t_in_item      start command or bit tick with sampled line level
//  o_out     out  t_out_item     line control, session status and decoded results
//  i_cfg     in   t_cfg_write    write of crc_seed (index 0) or error_grace (index 1)
//
//  One item per clock cycle sustained while o_out is taken; each item is done in one
//  pass through the session logic between the input register and the result register,
//  which holds its result for o_out. i_in stalls only when both registers are full
//  and o_out is not taken. Configuration writes are always accepted (i_cfg.ready is
//  tied high). Reset is synchronous and active low; no clearing pass follows it.

module one_wire_request_response_engine (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    owre_chan_if.sink    i_in,
    owre_chan_if.source  o_out,
    owre_chan_if.sink    i_cfg
);
    import owre_pkg::*;

    t_cfg      cfg;
    logic      item_valid;
    t_in_item  item;
    logic      take;

    assign i_cfg.ready = 1'b1;

    owre_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr       (i_cfg.data),
        .o_cfg      (cfg)
    );

    owre_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ready (i_in.ready),
        .o_valid (item_valid),
        .o_item  (item),
        .i_take  (take)
    );

    owre_session u_session (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .o_out_valid  (o_out.valid),
        .o_out        (o_out.data),
        .i_out_ready  (o_out.ready)
    );

endmodule

`default_nettype wire

// ----- sim/tb_one_wire_request_response_engine.sv -----
// Testbench for the one-wire request/response engine: drives start commands and bit ticks,
// predicts every result item in a session scoreboard and checks them field by field.
// Depends on owre_pkg, owre_chan_if and the one_wire_request_response_engine RTL.
`timescale 1ns / 1ps

import owre_pkg::*;

class wire_session_board;
    logic [7:0]  crc_seed;
    logic [6:0]  error_grace;
    t_phase      phase;
    logic [5:0]  bit_count;
    logic [31:0] shift_reg;
    logic [7:0]  pending_req;
    logic [6:0]  rx_count;
    logic [15:0] err_total;
    logic [7:0]  panel;
    logic [14:0] firmware;
    logic        backlight;
    logic        drv_level;
    logic        drv_en;
    t_out_item   awaited_outputs[$];
    int          mismatches;
    int          outputs_checked;

    function new();
        crc_seed        = CRC_SEED_RST;
        error_grace     = GRACE_RST;
        phase           = PH_IDLE;
        bit_count       = '0;
        shift_reg       = '0;
        pending_req     = '0;
        rx_count        = '0;
        err_total       = '0;
        panel           = '0;
        firmware        = '0;
        backlight       = 1'b0;
        drv_level       = 1'b1;
        drv_en          = 1'b0;
        mismatches      = 0;
        outputs_checked = 0;
    endfunction

    function logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function logic [7:0] frame_crc(logic [7:0] b3, logic [7:0] b2, logic [7:0] b1);
        return crc8_fold(crc8_fold(crc8_fold(crc_seed, b3), b2), b1);
    endfunction

    function void apply_setting(t_cfg_write w);
        case (w.reg_index)
            CFG_CRC_SEED:    crc_seed = w.wdata;
            CFG_ERROR_GRACE: error_grace = w.wdata[6:0];
            default: ;
        endcase
    endfunction

    // Advances the session by one command and returns the result item it causes.
    function t_out_item advance_session(t_in_item it);
        t_out_item  e;
        logic [7:0] b3, b2, b1, b0;
        e = '0;
        if (it.action == ACT_START) begin
            if (phase != PH_IDLE) begin
                e.session_status = ST_REFUSED;
            end else begin
                shift_reg   = {it.request_code, crc8_fold(crc_seed, it.request_code), 16'h0000};
                pending_req = it.request_code;
                bit_count   = 6'd1;
                phase       = PH_START;
                drv_en      = 1'b1;
                drv_level   = 1'b0;
            end
        end else if (phase != PH_IDLE) begin
            bit_count = bit_count - 6'd1;
            case (phase)
                PH_START: begin
                    if (bit_count == 0) begin
                        bit_count = REQ_BITS;
                        phase     = PH_REQUEST;
                    end
                end
                PH_REQUEST: begin
                    drv_level = shift_reg[31];
                    shift_reg = shift_reg << 1;
                    if (bit_count == 0) begin
                        bit_count = GAP_TICKS;
                        phase     = PH_WAITING;
                    end
                end
                PH_WAITING: begin
                    if (bit_count == 0) begin
                        bit_count = RESP_BITS;
                        phase     = PH_RESPONSE;
                    end
                    // The line is released on the first of the two gap ticks.
                    if (bit_count == 1) begin
                        drv_level = 1'b1;
                        drv_en    = 1'b0;
                    end
                end
                PH_RESPONSE: begin
                    shift_reg = {shift_reg[30:0], it.line_level};
                    if (bit_count == 0) begin
                        {b3, b2, b1, b0} = shift_reg;
                        bit_count = GAP_TICKS;
                        phase     = PH_STOPPING;
                        drv_level = 1'b1;
                        drv_en    = 1'b1;
                        if (rx_count < RX_COUNT_MAX) rx_count++;
                        if (frame_crc(b3, b2, b1) != b0) begin
                            e.session_status = ST_CRC_ERROR;
                            if (rx_count > error_grace && err_total != ERR_COUNT_MAX) begin
                                err_total++;
                            end
                        end else begin
                            e.session_status = ST_ACCEPTED;
                            if (pending_req == REQ_TOUCH) begin
                                e.result_kind   = KIND_TOUCH;
                                e.touch_x       = {b3[7:4], b2};
                                e.touch_y       = {b3[3:0], b1};
                                e.touch_pressed = (e.touch_x != COORD_NONE) &&
                                                  (e.touch_y != COORD_NONE);
                            end else if (pending_req == REQ_PANEL_INFO) begin
                                e.result_kind = KIND_INFO;
                                if (b3 != NO_PANEL) begin
                                    panel    = b3;
                                    firmware = 15'(b2) * 15'd100 + 15'(b1);
                                end
                            end else begin
                                e.result_kind = KIND_BACKLIGHT;
                                backlight     = 1'b1;
                            end
                        end
                    end
                end
                PH_STOPPING: begin
                    if (bit_count == 0) phase = PH_IDLE;
                end
                default: phase = PH_IDLE;
            endcase
        end
        e.line_drive        = drv_level;
        e.line_drive_enable = drv_en;
        e.timer_active      = (phase != PH_IDLE);
        e.panel_type        = panel;
        e.firmware_version  = firmware;
        e.error_count       = err_total;
        e.backlight_ready   = backlight;
        return e;
    endfunction

    function void take_command(t_in_item it);
        awaited_outputs.push_back(advance_session(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_output(t_out_item got);
        t_out_item e;
        if (awaited_outputs.size() == 0) begin
            $error("result item arrived with no expectation waiting");
            mismatches++;
            return;
        end
        e = awaited_outputs.pop_front();
        outputs_checked++;
        compare_field("line_drive", e.line_drive, got.line_drive);
        compare_field("line_drive_enable", e.line_drive_enable, got.line_drive_enable);
        compare_field("timer_active", e.timer_active, got.timer_active);
        compare_field("session_status", e.session_status, got.session_status);
        compare_field("result_kind", e.result_kind, got.result_kind);
        compare_field("touch_x", e.touch_x, got.touch_x);
        compare_field("touch_y", e.touch_y, got.touch_y);
        compare_field("touch_pressed", e.touch_pressed, got.touch_pressed);
        compare_field("panel_type", e.panel_type, got.panel_type);
        compare_field("firmware_version", e.firmware_version, got.firmware_version);
        compare_field("error_count", e.error_count, got.error_count);
        compare_field("backlight_ready", e.backlight_ready, got.backlight_ready);
    endfunction

    function int outstanding();
        return awaited_outputs.size();
    endfunction
endclass

module tb_one_wire_request_response_engine;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 420;
    localparam int SESSION_TICKS = 53;
    localparam int FIRST_RX_TICK = 20;
    localparam int LAST_RX_TICK  = 51;
    localparam int PHASE_ITEMS   = 70;

    logic i_clk = 1'b0;
    logic i_rst_n;

    owre_chan_if #(.T(t_in_item))   in_ch ();
    owre_chan_if #(.T(t_out_item))  out_ch ();
    owre_chan_if #(.T(t_cfg_write)) cfg_ch ();

    wire_session_board sb = new();

    int src_burst  = 0;
    int sink_burst = 0;
    int sent_items = 0;

    one_wire_request_response_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Transfers are observed at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_output(out_ch.data);
            if (in_ch.valid && in_ch.ready) sb.take_command(in_ch.data);
            if (cfg_ch.valid && cfg_ch.ready) sb.apply_setting(cfg_ch.data);
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one or a run with none.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic t_in_item make_item(t_action act, logic [7:0] req, logic line);
        t_in_item it;
        it.action       = act;
        it.request_code = req;
        it.line_level   = line;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap(src_burst);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_items++;
    endtask

    task automatic send_tick(logic line);
        send_item(make_item(ACT_TICK, 8'($urandom), line));
    endtask

    task automatic send_random_ticks(int n);
        repeat (n) send_tick(1'($urandom));
    endtask

    // One full session: start, request bits, gap, the 32-bit reply on the line, stop.
    // A refused start can be slipped in before any tick of the session.
    task automatic run_session(logic [7:0] req, logic [7:0] b3, logic [7:0] b2,
                               logic [7:0] b1, bit good, int refuse_at);
        logic [7:0]  crc;
        logic [31:0] frame;
        crc = sb.frame_crc(b3, b2, b1);
        if (!good) crc = crc ^ 8'($urandom_range(1, 255));
        frame = {b3, b2, b1, crc};
        send_item(make_item(ACT_START, req, 1'($urandom)));
        for (int k = 1; k <= SESSION_TICKS; k++) begin
            if (k == refuse_at) send_item(make_item(ACT_START, 8'($urandom), 1'($urandom)));
            if (k >= FIRST_RX_TICK && k <= LAST_RX_TICK) begin
                send_tick(frame[LAST_RX_TICK - k]);
            end else begin
                send_tick(1'($urandom));
            end
        end
    endtask

    task automatic random_session();
        logic [7:0] req, b3, b2, b1;
        int         r;
        r   = $urandom_range(0, 99);
        req = (r < 40) ? REQ_TOUCH : (r < 70) ? REQ_PANEL_INFO : 8'($urandom);
        b3  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
        b2  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
        b1  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
        run_session(req, b3, b2, b1, $urandom_range(0, 99) < 75,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, SESSION_TICKS) : -1);
    endtask

    // Idle ticks, sessions cut short, or arbitrary items.
    task automatic noise_burst();
        case ($urandom_range(0, 2))
            0: send_random_ticks($urandom_range(1, 4));
            1: begin
                send_item(make_item(ACT_START, 8'($urandom), 1'($urandom)));
                send_random_ticks($urandom_range(1, 40));
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    send_item(make_item(t_action'($urandom_range(0, 1)), 8'($urandom),
                                        1'($urandom)));
                end
            end
        endcase
    endtask

    task automatic random_phase(int n);
        int stop_at;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 99) < 80) random_session();
            else noise_burst();
        end
    endtask

    // Enough ticks to carry any session left open back to idle.
    task automatic close_sessions();
        send_random_ticks(SESSION_TICKS + 7);
    endtask

    task automatic wait_quiet();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        if (sb.outstanding() != 0) begin
            $error("%0d expected result items never arrived", sb.outstanding());
            sb.mismatches++;
        end
    endtask

    task automatic write_setting(t_cfg_idx idx, logic [7:0] value);
        @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.data.reg_index <= idx;
        cfg_ch.data.wdata     <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off that fills the block.
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && sb.outputs_checked >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_ch.ready <= 1'b0;
                end
            end
            repeat (pick_gap(sink_burst)) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sessions at the reset settings.
        send_tick(1'b0);
        send_tick(1'b1);
        run_session(REQ_TOUCH, 8'hFF, 8'hFF, 8'hFF, 1, -1);
        run_session(REQ_TOUCH, 8'h00, 8'h00, 8'h00, 1, 7);
        run_session(REQ_PANEL_INFO, NO_PANEL, 8'h0C, 8'h22, 1, -1);
        run_session(REQ_PANEL_INFO, 8'h5A, 8'hFF, 8'hFF, 1, 30);
        run_session(8'h00, 8'h12, 8'h34, 8'h56, 0, -1);
        run_session(8'hFF, 8'hA5, 8'h00, 8'hFF, 1, SESSION_TICKS);
        close_sessions();
        wait_quiet();

        // Errors counted from the first reply.
        write_setting(CFG_CRC_SEED, 8'h00);
        write_setting(CFG_ERROR_GRACE, 8'd0);
        random_phase(PHASE_ITEMS);
        close_sessions();
        wait_quiet();

        // With the largest grace errors are never counted.
        write_setting(CFG_CRC_SEED, 8'hFF);
        write_setting(CFG_ERROR_GRACE, {1'b0, RX_COUNT_MAX});
        random_phase(PHASE_ITEMS);
        close_sessions();
        wait_quiet();

        write_setting(CFG_CRC_SEED, 8'($urandom));
        write_setting(CFG_ERROR_GRACE, {1'b0, 7'($urandom)});
        random_phase(PHASE_ITEMS);
        close_sessions();
        wait_quiet();
        repeat (4) @(negedge i_clk);

        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
